// ----- hdl/cnc_pkg.sv -----
// shared types and constants for the counter to nanoseconds converter
// no dependencies; compiled first

package cnc_pkg;

	// conversion constants
	localparam logic [62:0] NS_PER_SEC       = 63'd1000000000;
	localparam logic [11:0] MAX_CONV_SECONDS = 12'd3600;
	localparam logic [5:0]  MAX_SHIFT        = 6'd32;
	localparam logic [31:0] RATE_RESET       = 32'd24000000;

	// calibration divider: 63-bit dividend, one quotient bit per cycle
	localparam int DIV_W     = 63;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_RATE      = 2'd0,
		CFG_EPOCH_NS  = 2'd1,
		CFG_EPOCH_CYC = 2'd2
	} cfg_idx_t;

	// result of one calibration run
	typedef struct packed {
		logic        done;
		logic [31:0] mult;
		logic [5:0]  shift;
	} cal_res_t;

endpackage

// ----- hdl/cnc_if.sv -----
// request channels of the counter to nanoseconds converter
// no dependencies

interface cnc_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] counter_value;

	modport source (output valid, output counter_value, input ready);
	modport sink (input valid, input counter_value, output ready);
endinterface

interface cnc_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] time_ns;
	logic [31:0] used_mult;
	logic [5:0]  used_shift;

	modport source (output valid, output time_ns, output used_mult, output used_shift,
		input ready);
	modport sink (input valid, input time_ns, input used_mult, input used_shift,
		output ready);
endinterface

// ----- hdl/cnc_cal.sv -----
// mult/shift calibration: bit count of the range limit, then a restoring divider
// shared over the shift search; depends on cnc_pkg

module cnc_cal import cnc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] rate,
	output cal_res_t    res
);

	typedef enum logic [4:0] {
		C_IDLE  = 5'b00001,
		C_LIMIT = 5'b00010,
		C_LOAD  = 5'b00100,
		C_DIV   = 5'b01000,
		C_CHECK = 5'b10000
	} cal_state_t;

	cal_state_t           state_q;
	logic [31:0]          rate_q;
	logic [11:0]          t_q;
	logic [5:0]           limit_q;
	logic [5:0]           sh_q;
	logic [DIV_W-1:0]     div_q;
	logic [31:0]          rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [31:0]          mult_q;
	logic [5:0]           shift_q;

	logic [31:0]      rate_eff;
	logic [43:0]      t_full;
	logic [32:0]      rem_sh;
	logic [32:0]      rem_dif;
	logic             rem_ge;
	logic [DIV_W-1:0] load_val;
	logic             fits;

	// a zero rate counts as one; range limit source is (3600 * rate) >> 32
	assign rate_eff = (rate == '0) ? 32'd1 : rate;
	assign t_full   = 44'(MAX_CONV_SECONDS) * 44'(rate_eff);

	// one restoring division step
	assign rem_sh  = {rem_q, div_q[DIV_W-1]};
	assign rem_dif = rem_sh - {1'b0, rate_q};
	assign rem_ge  = (rem_sh >= {1'b0, rate_q});

	// dividend for the current shift: (1e9 << shift) + rate / 2
	assign load_val = (NS_PER_SEC << sh_q) + DIV_W'(rate_q[31:1]);

	// quotient fits the accuracy limit
	assign fits = ((div_q >> limit_q) == '0);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
			t_q     <= '0;
			limit_q <= '0;
			sh_q    <= '0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				C_IDLE: begin
					if (start) begin
						t_q     <= t_full[43:32];
						limit_q <= MAX_SHIFT;
						sh_q    <= MAX_SHIFT;
						state_q <= C_LIMIT;
					end
				end
				C_LIMIT: begin
					if (t_q != '0) begin
						t_q     <= t_q >> 1;
						limit_q <= limit_q - 6'd1;
					end else begin
						state_q <= C_LOAD;
					end
				end
				C_LOAD: begin
					cnt_q   <= '0;
					state_q <= C_DIV;
				end
				C_DIV: begin
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
						state_q <= C_CHECK;
					end
				end
				C_CHECK: begin
					if (fits || sh_q == 6'd1) begin
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end else begin
						sh_q    <= sh_q - 6'd1;
						state_q <= C_LOAD;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					rate_q <= rate_eff;
				end
			end
			C_LOAD: begin
				div_q <= load_val;
				rem_q <= '0;
			end
			C_DIV: begin
				div_q <= {div_q[DIV_W-2:0], rem_ge};
				rem_q <= rem_ge ? rem_dif[31:0] : rem_sh[31:0];
			end
			C_CHECK: begin
				if (fits || sh_q == 6'd1) begin
					mult_q  <= div_q[31:0];
					shift_q <= fits ? sh_q : 6'd0;
				end
			end
			default: ;
		endcase
	end

	assign res = '{done: done_q, mult: mult_q, shift: shift_q};

endmodule

// ----- hdl/counter_to_nanoseconds_converter.sv -----
// Counter to nanoseconds converter.
// Input channel in_ch carries a raw 64-bit counter reading; output channel out_ch
// returns time_ns = (((counter - epoch_cycles) * mult) >> shift) + epoch_nanoseconds
// together with the mult and shift used. Both channels use valid/ready.
// Registers on the write port: counter_rate, epoch_nanoseconds, epoch_cycles.
// Once calibrated, an accepted request passes the states MLO, MHI, ACC, SHF and
// ADD to the output register; a new request is taken only back in IDLE. The 32x32
// multiplier is used twice per request and the 96-bit product passes an accumulate,
// a shift and an add stage. Calibration: while the stored mult is zero a request
// first runs the calibration unit: bit counting of the range limit, then for each
// tried shift one load, a division of the 63-bit dividend and a check.
// Reset clears the stored mult/shift, so the first request calibrates. Register
// writes after that do not recalibrate.
// A stalled receiver holds the result in the output register; one further request
// is accepted and processed meanwhile and waits in the final stage.
// Depends on cnc_pkg, cnc_if and cnc_cal.

module counter_to_nanoseconds_converter import cnc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cnc_in_if.sink     in_ch,
	cnc_out_if.source  out_ch,
	input  logic       cfg_wen,
	input  logic [1:0] cfg_index,
	input  logic [63:0] cfg_data
);

	typedef enum logic [6:0] {
		T_IDLE = 7'b0000001,
		T_CAL  = 7'b0000010,
		T_MLO  = 7'b0000100,
		T_MHI  = 7'b0001000,
		T_ACC  = 7'b0010000,
		T_SHF  = 7'b0100000,
		T_ADD  = 7'b1000000
	} top_state_t;

	top_state_t  state_q;
	logic [31:0] rate_q;
	logic [63:0] epoch_ns_q;
	logic [63:0] epoch_cyc_q;
	logic [31:0] mult_q;
	logic [5:0]  shift_q;
	logic [63:0] cyc_q;
	logic [63:0] prod_q;
	logic [95:0] acc_q;
	logic [63:0] res_q;
	logic        out_valid_q;
	logic [63:0] out_time_q;
	logic [31:0] out_mult_q;
	logic [5:0]  out_shift_q;

	logic        in_take;
	logic        cal_start;
	cal_res_t    cal_res;
	logic [31:0] mul_a;
	logic [63:0] mul_p;
	logic [95:0] shifted;
	logic        out_load;

	assign in_ch.ready = (state_q == T_IDLE);
	assign in_take     = in_ch.valid && in_ch.ready;
	assign cal_start   = in_take && (mult_q == '0);

	// calibration unit
	cnc_cal u_cal (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cal_start),
		.rate  (rate_q),
		.res   (cal_res)
	);

	// shared multiplier: low half of the cycle delta first, then high half
	assign mul_a   = (state_q == T_MLO) ? cyc_q[31:0] : cyc_q[63:32];
	assign mul_p   = 64'(mul_a) * 64'(mult_q);
	assign shifted = acc_q >> shift_q;

	assign out_load = (state_q == T_ADD) && (!out_valid_q || out_ch.ready);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q      <= RATE_RESET;
			epoch_ns_q  <= '0;
			epoch_cyc_q <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_RATE:      rate_q      <= cfg_data[31:0];
				CFG_EPOCH_NS:  epoch_ns_q  <= cfg_data;
				CFG_EPOCH_CYC: epoch_cyc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and stored mult/shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			mult_q  <= '0;
			shift_q <= '0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (in_take) begin
						state_q <= cal_start ? T_CAL : T_MLO;
					end
				end
				T_CAL: begin
					if (cal_res.done) begin
						mult_q  <= cal_res.mult;
						shift_q <= cal_res.shift;
						state_q <= T_MLO;
					end
				end
				T_MLO: state_q <= T_MHI;
				T_MHI: state_q <= T_ACC;
				T_ACC: state_q <= T_SHF;
				T_SHF: state_q <= T_ADD;
				T_ADD: begin
					if (out_load) begin
						state_q <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	// conversion datapath
	always_ff @(posedge clk) begin
		if (in_take) begin
			cyc_q <= in_ch.counter_value - epoch_cyc_q;
		end
		case (state_q)
			T_MLO: prod_q <= mul_p;
			T_MHI: begin
				acc_q  <= {32'd0, prod_q};
				prod_q <= mul_p;
			end
			T_ACC: acc_q <= {acc_q[95:32] + prod_q, acc_q[31:0]};
			T_SHF: res_q <= shifted[63:0];
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_time_q  <= res_q + epoch_ns_q;
			out_mult_q  <= mult_q;
			out_shift_q <= shift_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.time_ns    = out_time_q;
	assign out_ch.used_mult  = out_mult_q;
	assign out_ch.used_shift = out_shift_q;

endmodule

// ----- hdl/cnc_check.sv -----
// port-level checks for the counter to nanoseconds converter, bound to the top level
// depends on counter_to_nanoseconds_converter

module cnc_check (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] time_ns,
	input logic [31:0] used_mult,
	input logic [5:0]  used_shift
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(time_ns) &&
		$stable(used_mult) && $stable(used_shift))
		else $error("stalled result changed");

	// the block is busy in the cycle after taking a request
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// no result can appear in the cycle right after a request
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early");

	// shift never exceeds the search start
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> used_shift <= 6'd32)
		else $error("shift out of range");

endmodule

bind counter_to_nanoseconds_converter cnc_check u_cnc_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.time_ns   (out_ch.time_ns),
	.used_mult (out_ch.used_mult),
	.used_shift(out_ch.used_shift)
);

// ----- tb/sv/tb_counter_to_nanoseconds_converter.sv -----
`timescale 1ns / 1ps
// testbench for counter_to_nanoseconds_converter: directed and random counter readings,
// each result checked against an in-bench mult/shift calibration and conversion model
// depends on cnc_pkg, cnc_in_if, cnc_out_if and the converter rtl

module tb_counter_to_nanoseconds_converter;
	import cnc_pkg::*;

	typedef struct {
		logic [63:0] time_ns;
		logic [31:0] mult;
		logic [5:0]  shift;
	} conversion_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	cfg_idx_t    cfg_index;
	logic [63:0] cfg_data;

	cnc_in_if  in_ch ();
	cnc_out_if out_ch ();

	counter_to_nanoseconds_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// mirror of the register file and the calibrated pair
	logic [31:0] rate_reg     = RATE_RESET;
	logic [63:0] epoch_ns_reg = '0;
	logic [63:0] epoch_cyc_reg = '0;
	logic [31:0] cal_mult     = '0;
	logic [5:0]  cal_shift    = '0;

	logic [63:0] pending_counts[$];
	conversion_t expected_times[$];
	conversion_t head_res;

	int   queued_cnt   = 0;
	int   accepted_cnt = 0;
	int   error_cnt    = 0;
	int   src_gap;
	int   sink_stall;
	bit   src_idle_en;
	bit   sink_idle_en;
	logic hold_off;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly short gaps, now and then a long one
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// accuracy limit from the rate, then the highest shift whose mult fits it
	function automatic void calibrate_mult_shift();
		logic [63:0] rate;
		logic [63:0] t;
		logic [63:0] m;
		int          limit;
		int          sh;
		bit          fit;
		rate = (rate_reg == 0) ? 64'd1 : {32'd0, rate_reg};
		t = (64'd3600 * rate) >> 32;
		limit = 32;
		while (t != 0) begin
			t = t >> 1;
			limit--;
		end
		sh = 32;
		fit = 1'b0;
		m = '0;
		while (sh > 0 && !fit) begin
			m = ((64'd1000000000 << sh) + rate / 2) / rate;
			if ((m >> limit) == 0)
				fit = 1'b1;
			else
				sh--;
		end
		cal_mult = m[31:0];
		cal_shift = sh[5:0];
	endfunction

	// expected time for one accepted counter reading
	function automatic void predict_conversion(logic [63:0] count);
		logic [63:0] delta;
		logic [95:0] product;
		conversion_t res;
		if (cal_mult == 0)
			calibrate_mult_shift();
		delta = count - epoch_cyc_reg;
		product = {32'd0, delta} * {64'd0, cal_mult};
		product = product >> cal_shift;
		res.time_ns = product[63:0] + epoch_ns_reg;
		res.mult = cal_mult;
		res.shift = cal_shift;
		expected_times.push_back(res);
	endfunction

	// readings mostly just after the epoch, some before it, some far off
	function automatic logic [63:0] pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return epoch_cyc_reg + {32'd0, $urandom};
		else if (r < 60)
			return epoch_cyc_reg + 64'($urandom_range(0, 15));
		else if (r < 72)
			return epoch_cyc_reg - {32'd0, $urandom};
		else if (r < 82)
			return epoch_cyc_reg + {24'd0, 8'($urandom_range(0, 255)), $urandom};
		else
			return {$urandom, $urandom};
	endfunction

	task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			CFG_RATE:      rate_reg = value[31:0];
			CFG_EPOCH_NS:  epoch_ns_reg = value;
			CFG_EPOCH_CYC: epoch_cyc_reg = value;
			default: ;
		endcase
	endtask

	task automatic queue_count(logic [63:0] value);
		pending_counts.push_back(value);
		queued_cnt++;
	endtask

	// every request taken and answered, then let the pipeline settle
	task automatic wait_idle();
		while (accepted_cnt != queued_cnt || expected_times.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.counter_value <= '0;
			src_gap = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_conversion(in_ch.counter_value);
				accepted_cnt++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_counts.size() != 0) begin
					in_ch.valid <= 1'b1;
					in_ch.counter_value <= pending_counts.pop_front();
					if (src_idle_en)
						src_gap = rand_gap();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			sink_stall = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_times.size() == 0) begin
					$error("result with no request pending: time_ns %h", out_ch.time_ns);
					error_cnt++;
				end else begin
					head_res = expected_times.pop_front();
					if (out_ch.time_ns !== head_res.time_ns) begin
						$error("time_ns mismatch: expected %h, got %h",
							head_res.time_ns, out_ch.time_ns);
						error_cnt++;
					end
					if (out_ch.used_mult !== head_res.mult) begin
						$error("used_mult mismatch: expected %h, got %h",
							head_res.mult, out_ch.used_mult);
						error_cnt++;
					end
					if (out_ch.used_shift !== head_res.shift) begin
						$error("used_shift mismatch: expected %0d, got %0d",
							head_res.shift, out_ch.used_shift);
						error_cnt++;
					end
				end
			end
			if (hold_off) begin
				out_ch.ready <= 1'b0;
			end else if (sink_stall > 0) begin
				sink_stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (sink_idle_en)
					sink_stall = rand_gap();
			end
		end
	end

	// long receiver hold-offs while the sender keeps offering, so the input backs up
	initial begin
		hold_off = 1'b0;
		while (accepted_cnt < 300)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (150) @(posedge clk);
		hold_off <= 1'b0;
		while (accepted_cnt < 1000)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (150) @(posedge clk);
		hold_off <= 1'b0;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("** counter_to_nanoseconds_converter: FAILED **");
		$finish;
	end

	// stimulus
	initial begin
		int          r;
		int          phase;
		logic [63:0] v;
		in_ch.valid = 1'b0;
		in_ch.counter_value = '0;
		out_ch.ready = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = CFG_RATE;
		cfg_data = '0;
		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// calibration happens once after the only reset, so the rate it sees
		// (zero, one, the maximum, the reset value or a random one) is drawn per seed
		r = $urandom_range(0, 5);
		case (r)
			0: v = 64'd0;
			1: v = 64'd1;
			2: v = 64'hFFFF_FFFF;
			3: v = {32'd0, RATE_RESET};
			4: v = 64'($urandom_range(1000, 100000000));
			default: v = {32'd0, $urandom};
		endcase
		write_reg(CFG_RATE, v);
		write_reg(CFG_EPOCH_NS, 64'd0);
		write_reg(CFG_EPOCH_CYC, 64'd0);

		// field extremes with a zero epoch; the first request calibrates
		queue_count(64'd0);
		queue_count(64'd1);
		queue_count(64'h0000_0000_FFFF_FFFF);
		queue_count(64'h0000_0001_0000_0000);
		queue_count(64'h8000_0000_0000_0000);
		queue_count(64'hFFFF_FFFF_FFFF_FFFF);
		wait_idle();

		// readings around a mid-range epoch, time wrapping past the top
		write_reg(CFG_EPOCH_CYC, 64'h8000_0000_0000_0000);
		write_reg(CFG_EPOCH_NS, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_count(64'h8000_0000_0000_0000);
		queue_count(64'h7FFF_FFFF_FFFF_FFFF);
		queue_count(64'h8000_0000_0000_0001);
		queue_count(64'd0);
		queue_count(64'hFFFF_FFFF_FFFF_FFFF);
		queue_count(64'h0000_0000_0000_0001);
		wait_idle();

		// rate change after calibration must leave mult/shift alone
		write_reg(CFG_RATE, 64'd0);
		write_reg(CFG_EPOCH_NS, 64'd0);
		write_reg(CFG_EPOCH_CYC, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_count(64'hFFFF_FFFF_FFFF_FFFF);
		queue_count(64'd0);
		queue_count(64'h5555_5555_5555_5555);
		queue_count(64'hAAAA_AAAA_AAAA_AAAA);
		wait_idle();

		write_reg(CFG_RATE, 64'hFFFF_FFFF);
		write_reg(CFG_EPOCH_NS, 64'h0123_4567_89AB_CDEF);
		write_reg(CFG_EPOCH_CYC, 64'd0);
		queue_count(64'hFFFF_FFFF_0000_0000);
		repeat (3) queue_count({$urandom, $urandom});
		wait_idle();

		// random phases, each with its own epoch and idling pattern
		for (phase = 0; phase < 8; phase++) begin
			r = $urandom_range(0, 3);
			write_reg(CFG_EPOCH_NS, (r == 0) ? 64'd0 :
				(r == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
			r = $urandom_range(0, 3);
			write_reg(CFG_EPOCH_CYC, (r == 0) ? 64'd0 :
				(r == 1) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
			r = $urandom_range(0, 2);
			write_reg(CFG_RATE, (r == 0) ? 64'd0 :
				(r == 1) ? 64'hFFFF_FFFF : {32'd0, $urandom});
			src_idle_en <= (phase % 4 != 1) && (phase != 7);
			sink_idle_en <= (phase % 4 != 2) && (phase != 7);
			repeat (175) queue_count(pick_count());
			wait_idle();
		end

		if (error_cnt == 0)
			$display("** counter_to_nanoseconds_converter: PASSED **");
		else
			$display("** counter_to_nanoseconds_converter: FAILED **");
		$finish;
	end

endmodule
